/* rtl/lcg64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg64_pkg: shared definitions for the 64-bit LCG draw unit
// Operation codes, generator constants and the outer perfect shuffle.
// ----------------------------------------------------------------------------
package lcg64_pkg;

    typedef enum logic [1:0] {
        OP_SEED    = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;

    function automatic logic [31:0] outer_shuffle(input logic [31:0] value);
        logic [31:0] v;
        v = value;
        v = ((v & 32'h0000FF00) << 8) | ((v >> 8) & 32'h0000FF00) | (v & 32'hFF0000FF);
        v = ((v & 32'h00F000F0) << 4) | ((v >> 4) & 32'h00F000F0) | (v & 32'hF00FF00F);
        v = ((v & 32'h0C0C0C0C) << 2) | ((v >> 2) & 32'h0C0C0C0C) | (v & 32'hC3C3C3C3);
        v = ((v & 32'h22222222) << 1) | ((v >> 1) & 32'h22222222) | (v & 32'h99999999);
        return v;
    endfunction

endpackage

/* rtl/lcg64_random_with_bounded_draw_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg64_random_with_bounded_draw_unit: 64-bit LCG with raw and bounded draws
// Accepts one command transaction on the input channel (seed, raw draw or
// bounded draw) and returns one result transaction on the output channel.
// Both channels use valid/ready; a transaction moves when both are high.
// The generator step runs on one shared 32x32 multiplier in states ST_MUL0,
// ST_MUL1 and ST_MUL2, followed by the add states ST_ADD1 and ST_ADD2; a
// bounded draw then runs a restoring modulo by the span, one quotient bit
// per cycle over the 32 bits of the draw. Seed, unused op or equal bounds
// go straight to the finish state, and a bounded draw over the full 32-bit
// span skips the modulo. The next command can be accepted once the
// sequencer is back in idle after the result is loaded. One command is in
// work at a time: in_ready is high only while the sequencer is idle, so a
// command may be accepted while the previous result still waits.
// If the receiver stalls, the finished result holds in the sequencer until
// the output register is free, and the output holds stable meanwhile.
// Reset clears the generator state to zero and empties the output.
// ----------------------------------------------------------------------------
module lcg64_random_with_bounded_draw_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] seed_value,
    input  logic signed [31:0] bound_one,
    input  logic signed [31:0] bound_two,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] raw_value,
    output logic signed [31:0] bounded_value
);
    import lcg64_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_ADD1,
        ST_ADD2,
        ST_MOD,
        ST_FIN
    } state_t;

    state_t      state_reg;
    logic [63:0] gen_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    op_t         op_reg;
    logic        equal_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic [31:0] span_reg;
    logic [32:0] rem_reg;
    logic [31:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    logic [31:0] raw_value_reg;
    logic [31:0] bounded_value_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] step_sum;
    logic [32:0] rem_shift;
    logic        rem_ge;
    logic        a_lt_b;
    logic        out_free;

    always_comb
    begin
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = gen_reg[31:0];
                mul_b = LCG_MUL[63:32];
            end
            ST_MUL2:
            begin
                mul_a = gen_reg[63:32];
                mul_b = LCG_MUL[31:0];
            end
            default:
            begin
                mul_a = gen_reg[31:0];
                mul_b = LCG_MUL[31:0];
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign step_sum  = acc_reg + LCG_ADD;
    assign rem_shift = {rem_reg[31:0], div_reg[31]};
    assign rem_ge    = rem_shift >= {1'b0, span_reg};
    assign a_lt_b    = bound_one < bound_two;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign raw_value     = raw_value_reg;
    assign bounded_value = bounded_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
            equal_reg     <= 1'b0;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op_t'(op);
                        lo_reg    <= a_lt_b ? bound_one : bound_two;
                        hi_reg    <= a_lt_b ? bound_two : bound_one;
                        equal_reg <= (bound_one == bound_two);
                        case (op_t'(op))
                            OP_SEED:
                            begin
                                gen_reg   <= seed_value
                                             + {32'd0, outer_shuffle(seed_value[31:0])};
                                state_reg <= ST_FIN;
                            end
                            OP_RAW:
                            begin
                                state_reg <= ST_MUL0;
                            end
                            OP_BOUNDED:
                            begin
                                state_reg <= (bound_one == bound_two) ? ST_FIN : ST_MUL0;
                            end
                            default:
                            begin
                                state_reg <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_MUL0:
                begin
                    prod_reg  <= mul_p;
                    span_reg  <= hi_reg - lo_reg + 32'd1;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    prod_reg       <= mul_p;
                    state_reg      <= ST_ADD1;
                end
                ST_ADD1:
                begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    state_reg      <= ST_ADD2;
                end
                ST_ADD2:
                begin
                    gen_reg <= step_sum;
                    div_reg <= step_sum[63:32];
                    cnt_reg <= 5'd31;
                    if (op_reg == OP_BOUNDED && span_reg != 32'd0)
                    begin
                        rem_reg   <= 33'd0;
                        state_reg <= ST_MOD;
                    end
                    else
                    begin
                        rem_reg   <= {1'b0, step_sum[63:32]};
                        state_reg <= ST_FIN;
                    end
                end
                ST_MOD:
                begin
                    rem_reg <= rem_ge ? (rem_shift - {1'b0, span_reg}) : rem_shift;
                    div_reg <= {div_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        raw_value_reg     <= (op_reg == OP_RAW) ? gen_reg[63:32] : 32'd0;
                        if (op_reg == OP_BOUNDED)
                        begin
                            bounded_value_reg <= equal_reg ? lo_reg : lo_reg + rem_reg[31:0];
                        end
                        else
                        begin
                            bounded_value_reg <= 32'd0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/lcg64_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg64_checker: port-level checks for the LCG draw unit
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module lcg64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] raw_value,
    input logic [31:0] bounded_value
);

    // A held result must not change before its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_value)
                                    && $stable(bounded_value))
        else $error("output changed while stalled");

    // The unit works on one command at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A result comes only after a command; none appears in the cycle after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // Only one of the two result fields can be nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && raw_value != 32'd0 |-> bounded_value == 32'd0)
        else $error("both result fields nonzero");

endmodule

bind lcg64_random_with_bounded_draw_unit lcg64_checker u_lcg64_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .raw_value     (raw_value),
    .bounded_value (bounded_value)
);
